FILE: hw/rtl/rtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC register block package
// Item types, register indexes, masks and the periodic interrupt period table.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int PERIOD_W = 29;
    localparam int LOW_COUNT = 14;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    localparam logic [3:0] IDX_SEC  = 4'd0;
    localparam logic [3:0] IDX_MIN  = 4'd2;
    localparam logic [3:0] IDX_HOUR = 4'd4;
    localparam logic [3:0] IDX_DOW  = 4'd6;
    localparam logic [3:0] IDX_DAY  = 4'd7;
    localparam logic [3:0] IDX_MON  = 4'd8;
    localparam logic [3:0] IDX_YEAR = 4'd9;
    localparam logic [3:0] IDX_A    = 4'd10;
    localparam logic [3:0] IDX_B    = 4'd11;
    localparam logic [3:0] IDX_C    = 4'd12;
    localparam logic [3:0] IDX_D    = 4'd13;

    localparam logic [7:0] A_RESET = 8'h20;
    localparam logic [7:0] MASK_A  = 8'h7f;
    localparam logic [7:0] MASK_B  = 8'hd7;
    localparam logic [7:0] MASK_CD = 8'h00;
    localparam logic [7:0] MASK_ALL = 8'hff;
    localparam int A_UIP_BIT = 7;
    localparam int B_PIE_BIT = 6;

    // subsecond + 2192000 > 1e9
    localparam logic [29:0] UIP_LIMIT = 30'(1000000000 - (244 + 1948) * 1000);

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  reg_index;
        logic [7:0]  write_data;
        logic [19:0] elapsed_ns;
        logic [5:0]  now_seconds;
        logic [5:0]  now_minutes;
        logic [4:0]  now_hours;
        logic [2:0]  now_weekday;
        logic [4:0]  now_month_day;
        logic [3:0]  now_month;
        logic [7:0]  now_year;
        logic [29:0] now_subsecond_ns;
    } t_rtc_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
    } t_rtc_out;

    function automatic logic [PERIOD_W-1:0] rtc_period(input logic [3:0] sel);
        logic [PERIOD_W-1:0] p;
        case (sel)
            4'd1:    p = PERIOD_W'(3906250);
            4'd2:    p = PERIOD_W'(7812500);
            4'd3:    p = PERIOD_W'(122070);
            4'd4:    p = PERIOD_W'(244141);
            4'd5:    p = PERIOD_W'(488281);
            4'd6:    p = PERIOD_W'(976562);
            4'd7:    p = PERIOD_W'(1953125);
            4'd8:    p = PERIOD_W'(3906250);
            4'd9:    p = PERIOD_W'(7812500);
            4'd10:   p = PERIOD_W'(15625000);
            4'd11:   p = PERIOD_W'(31250000);
            4'd12:   p = PERIOD_W'(62500000);
            4'd13:   p = PERIOD_W'(125000000);
            4'd14:   p = PERIOD_W'(250000000);
            4'd15:   p = PERIOD_W'(500000000);
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] rtc_mod100(input logic [7:0] y);
        logic [7:0] r;
        if (y >= 8'd200) begin
            r = y - 8'd200;
        end else if (y >= 8'd100) begin
            r = y - 8'd100;
        end else begin
            r = y;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/rtc_registers_periodic_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC register file with periodic interrupt
// Byte register file with time loading, update-in-progress flag and a
// periodic countdown that raises an interrupt line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one item per
//   access: register read, register write or time tick. Output channel
//   (o_out_valid / i_out_ready / o_out_item) returns exactly one item per
//   input item: the byte read (zero for writes and ticks) and the interrupt
//   line level after the item.
//   The result is registered at the edge that accepts the item. Throughput
//   is one item per cycle while the receiver takes each result; an item is
//   accepted while the previous result is being taken in the same cycle.
//   When the receiver stalls, the result register holds and o_in_ready
//   drops until it is taken.
//   Registers 0 to 13 sit in flip-flops; the rest sit in a memory with one
//   valid bit per entry, so an entry not yet written reads as zero.
//   Reset clears all control state and registers (register A to 0x20);
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module rtc_registers_periodic_irq #(
    parameter int REG_COUNT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rtc_pkg::t_rtc_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rtc_pkg::t_rtc_out o_out_item
);
    import rtc_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    logic [7:0]          r_low [LOW_COUNT];
    logic [7:0]          n_low [LOW_COUNT];
    logic [7:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_mem_vld;
    logic                r_armed, n_armed;
    logic [PERIOD_W-1:0] r_rem, n_rem;
    logic                r_irq, n_irq;

    logic                r_out_valid;
    logic                r_sel_mem;
    logic                r_mem_ok;
    logic [7:0]          r_mem_rd;
    logic [7:0]          r_rd_low, n_rd_low;

    logic                accept;
    logic                in_range;
    logic                is_low;
    logic [3:0]          low_idx;
    logic [AW-1:0]       addr;
    logic                mem_wr, mem_rd;
    logic [7:0]          mask;
    logic [PERIOD_W-1:0] period;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = {2'b00, i_in_item.reg_index} < 8'(REG_COUNT);
    assign is_low     = i_in_item.reg_index < 6'(LOW_COUNT);
    assign low_idx    = i_in_item.reg_index[3:0];
    assign addr       = AW'(i_in_item.reg_index);
    assign period     = rtc_period(r_low[IDX_A][3:0]);
    assign mem_wr     = accept && i_in_item.action == ACT_WRITE && in_range && !is_low;
    assign mem_rd     = i_in_item.action == ACT_READ && in_range && !is_low;

    always_comb begin
        case (low_idx)
            IDX_A:        mask = MASK_A;
            IDX_B:        mask = MASK_B;
            IDX_C, IDX_D: mask = MASK_CD;
            default:      mask = MASK_ALL;
        endcase
    end

    always_comb begin
        n_low    = r_low;
        n_armed  = r_armed;
        n_rem    = r_rem;
        n_irq    = r_irq;
        n_rd_low = 8'h00;
        case (t_action'(i_in_item.action))
            ACT_READ: begin
                if (in_range && is_low) begin
                    if (low_idx == IDX_A) begin
                        n_low[IDX_A][A_UIP_BIT] = i_in_item.now_subsecond_ns > UIP_LIMIT;
                    end
                    if (low_idx < 4'd10) begin
                        n_low[IDX_SEC]  = {2'b00, i_in_item.now_seconds};
                        n_low[IDX_MIN]  = {2'b00, i_in_item.now_minutes};
                        n_low[IDX_HOUR] = {3'b000, i_in_item.now_hours};
                        n_low[IDX_DOW]  = {5'b00000, i_in_item.now_weekday} + 8'd1;
                        n_low[IDX_DAY]  = {3'b000, i_in_item.now_month_day};
                        n_low[IDX_MON]  = {4'b0000, i_in_item.now_month} + 8'd1;
                        n_low[IDX_YEAR] = rtc_mod100(i_in_item.now_year);
                    end
                    n_rd_low = n_low[low_idx];
                    if (low_idx == IDX_C) begin
                        n_irq = 1'b0;
                    end
                end
            end
            ACT_WRITE: begin
                if (in_range && is_low) begin
                    n_low[low_idx] = (r_low[low_idx] & ~mask) | (i_in_item.write_data & mask);
                    if (low_idx == IDX_B && !r_low[IDX_B][B_PIE_BIT]
                            && i_in_item.write_data[B_PIE_BIT]) begin
                        n_armed = period != '0;
                        n_rem   = period;
                    end
                end
            end
            ACT_TICK: begin
                if (r_armed) begin
                    if (PERIOD_W'(i_in_item.elapsed_ns) >= r_rem) begin
                        if (period == '0) begin
                            n_armed = 1'b0;
                            n_rem   = '0;
                        end else begin
                            n_rem = period;
                            if (r_low[IDX_B][B_PIE_BIT]) begin
                                n_irq = 1'b1;
                            end
                        end
                    end else begin
                        n_rem = r_rem - PERIOD_W'(i_in_item.elapsed_ns);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOW_COUNT; i++) begin
                r_low[i] <= (i == int'(IDX_A)) ? A_RESET : 8'h00;
            end
            r_armed      <= 1'b0;
            r_rem        <= '0;
            r_irq        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mem_vld    <= '0;
        end else begin
            if (accept) begin
                r_low   <= n_low;
                r_armed <= n_armed;
                r_rem   <= n_rem;
                r_irq   <= n_irq;
            end
            if (mem_wr) begin
                r_mem_vld[addr] <= 1'b1;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[addr] <= i_in_item.write_data;
        end
        if (accept) begin
            r_mem_rd  <= r_mem[addr];
            r_mem_ok  <= r_mem_vld[addr];
            r_sel_mem <= mem_rd;
            r_rd_low  <= n_rd_low;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_item.read_data = r_sel_mem ? (r_mem_ok ? r_mem_rd : 8'h00) : r_rd_low;
    assign o_out_item.irq_level = r_irq;

endmodule
